// ===== rtl/core/psrl_pkg.sv =====
// Shared types and constants of the per-source connection rate limiter.
package psrl_pkg;

   typedef struct packed {
      logic [31:0] client_ip;
      logic [47:0] now_ms;
   } req_type;

   typedef struct packed {
      logic accept;
      logic untracked;
   } rsp_type;

   localparam int unsigned CSR_INDEX_BITS = 3;
   localparam int unsigned CSR_DATA_BITS  = 16;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_WINDOW      = 3'd0,
      CSR_FAST_WINDOW = 3'd1,
      CSR_BURST_LIMIT = 3'd2,
      CSR_BLOCK       = 3'd3,
      CSR_BLOCK_EXT   = 3'd4
   } csr_index_type;

   localparam logic [15:0] WINDOW_MS_RESET          = 16'd5000;
   localparam logic [15:0] FAST_WINDOW_MS_RESET     = 16'd500;
   localparam logic [7:0]  BURST_LIMIT_RESET        = 8'd5;
   localparam logic [15:0] BLOCK_MS_RESET           = 16'd3000;
   localparam logic [15:0] BLOCK_EXTENSION_MS_RESET = 16'd250;

   typedef enum logic {
      ALU_SUB,
      ALU_ADD_SAT
   } alu_op_type;

endpackage

// ===== rtl/core/psrl_alu.sv =====
// Shared time adder/subtractor: saturating add or plain subtract, with a carry flag.
module psrl_alu
   import psrl_pkg::*;
#(
   parameter int unsigned WIDTH = 48
) (
   input  alu_op_type       op,
   input  logic [WIDTH-1:0] a,
   input  logic [WIDTH-1:0] b,
   output logic [WIDTH-1:0] result,
   output logic             carry
);

   logic [WIDTH-1:0] b_x;
   logic             cin;
   logic [WIDTH:0]   sum;

   always_comb begin
      b_x = (op == ALU_SUB) ? ~b : b;
      cin = (op == ALU_SUB);
   end

   assign sum   = {1'b0, a} + {1'b0, b_x} + {{WIDTH{1'b0}}, cin};
   // add: carry means overflow; sub: carry means a >= b (no borrow)
   assign carry = sum[WIDTH];

   always_comb begin
      if (op == ALU_ADD_SAT && sum[WIDTH]) begin
         result = {WIDTH{1'b1}};
      end else begin
         result = sum[WIDTH-1:0];
      end
   end

endmodule

// ===== rtl/core/per_source_connection_rate_limiter.sv =====
// Top level of the per-source connection rate limiter: table, sequencer and ports.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------------
//   req     | in        | req_valid/req_ready  | req_data  (client_ip, now_ms)
//   rsp     | out       | rsp_valid/rsp_ready  | rsp_data  (accept, untracked)
//   csr     | in        | csr_valid/csr_ready  | csr_index, csr_wdata
//
// One transaction at a time. The table is a memory with one read and one write
// port, scanned one slot per cycle, lowest slot first. A hit checks the block
// time; a blocked source extends its block, any other measures the gap, decides
// and may start a block, and then the slot is written back. A miss stores a new
// slot, or on a full table is accepted untracked; fill counts tracked sources.
// Reset is synchronous and clears the fill count, so no clearing pass is run.
// A finished result waits in the output register; req_ready stays low until
// the result is loaded there. The csr port is always ready.
module per_source_connection_rate_limiter
   import psrl_pkg::*;
#(
   parameter int unsigned ENTRIES   = 64,
   parameter int unsigned TIME_BITS = 48
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  req_type                           req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output rsp_type                           rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]         csr_index,
   input  logic [CSR_DATA_BITS-1:0]          csr_wdata
);

   localparam int unsigned AW = $clog2(ENTRIES);
   localparam int unsigned CW = $clog2(ENTRIES + 1);

   typedef struct packed {
      logic [31:0]          address;
      logic [TIME_BITS-1:0] last_time;
      logic [7:0]           attempts;
      logic [TIME_BITS-1:0] block_until;
   } slot_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MISS,
      ST_CHECK,
      ST_EXTEND,
      ST_GAP,
      ST_DECIDE,
      ST_BLOCK,
      ST_WRITE,
      ST_FINISH
   } state_type;

   // configuration registers
   logic [15:0] window_ff;
   logic [15:0] fast_window_ff;
   logic [7:0]  burst_limit_ff;
   logic [15:0] block_ff;
   logic [15:0] block_ext_ff;

   // sequencer
   state_type            state_ff;
   logic [CW-1:0]        fill_ff;
   logic [AW-1:0]        idx_ff;
   logic [AW-1:0]        hit_idx_ff;
   logic [31:0]          ip_ff;
   logic [TIME_BITS-1:0] now_ff;
   logic [TIME_BITS-1:0] gap_ff;
   slot_type             rec_ff;
   logic                 accept_ff;
   logic                 untracked_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_data_ff;

   // table memory
   slot_type             mem [ENTRIES];
   slot_type             rd_data_ff;
   logic [AW-1:0]        rd_addr;
   logic                 wr_en_ff;
   logic [AW-1:0]        wr_addr_ff;
   slot_type             wr_data_ff;

   // shared time unit
   alu_op_type           alu_op;
   logic [TIME_BITS-1:0] alu_a;
   logic [TIME_BITS-1:0] alu_b;
   logic [TIME_BITS-1:0] alu_result;
   logic                 alu_carry;

   // decision terms
   logic       in_window;
   logic       in_fast;
   logic [8:0] next_attempts;
   logic       over_limit;
   logic       last_slot;
   logic       finish_go;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

   // configuration writes; unknown indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff      <= WINDOW_MS_RESET;
         fast_window_ff <= FAST_WINDOW_MS_RESET;
         burst_limit_ff <= BURST_LIMIT_RESET;
         block_ff       <= BLOCK_MS_RESET;
         block_ext_ff   <= BLOCK_EXTENSION_MS_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_WINDOW:      window_ff      <= csr_wdata;
            CSR_FAST_WINDOW: fast_window_ff <= csr_wdata;
            CSR_BURST_LIMIT: burst_limit_ff <= csr_wdata[7:0];
            CSR_BLOCK:       block_ff       <= csr_wdata;
            CSR_BLOCK_EXT:   block_ext_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Read slot 0 on acceptance, then always one slot ahead of the compare.
   assign rd_addr = (state_ff == ST_IDLE) ? '0 : idx_ff + AW'(1);

   always_ff @(posedge clock) begin
      if (wr_en_ff) begin
         mem[wr_addr_ff] <= wr_data_ff;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // operand select for the shared adder
   always_comb begin
      alu_op = ALU_SUB;
      alu_a  = '0;
      alu_b  = '0;
      case (state_ff)
         ST_CHECK: begin
            // blocked when now < block_until, i.e. borrow
            alu_a = now_ff;
            alu_b = rec_ff.block_until;
         end
         ST_EXTEND: begin
            alu_op = ALU_ADD_SAT;
            alu_a  = rec_ff.block_until;
            alu_b  = TIME_BITS'(block_ext_ff);
         end
         ST_GAP: begin
            alu_a = now_ff;
            alu_b = rec_ff.last_time;
         end
         ST_BLOCK: begin
            alu_op = ALU_ADD_SAT;
            alu_a  = now_ff;
            alu_b  = TIME_BITS'(block_ff);
         end
         default: ;
      endcase
   end

   psrl_alu #(
      .WIDTH (TIME_BITS)
   ) u_alu (
      .op     (alu_op),
      .a      (alu_a),
      .b      (alu_b),
      .result (alu_result),
      .carry  (alu_carry)
   );

   always_comb begin
      in_window     = (gap_ff[TIME_BITS-1:16] == '0) && (gap_ff[15:0] <= window_ff);
      in_fast       = (gap_ff[TIME_BITS-1:16] == '0) && (gap_ff[15:0] <= fast_window_ff);
      next_attempts = {1'b0, rec_ff.attempts} + 9'd1;
      over_limit    = next_attempts > {1'b0, burst_limit_ff};
      last_slot     = (CW'(idx_ff) + CW'(1)) == fill_ff;
   end

   // load the output register once it is free
   assign finish_go = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         wr_en_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wr_en_ff <= (state_ff == ST_WRITE);
         if (finish_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  ip_ff        <= req_data.client_ip;
                  now_ff       <= TIME_BITS'(req_data.now_ms);
                  idx_ff       <= '0;
                  accept_ff    <= 1'b1;
                  untracked_ff <= 1'b0;
                  state_ff     <= (fill_ff == '0) ? ST_MISS : ST_SCAN;
               end
            end
            ST_SCAN: begin
               // compare the slot read last cycle; the first match wins
               if (rd_data_ff.address == ip_ff) begin
                  rec_ff     <= rd_data_ff;
                  hit_idx_ff <= idx_ff;
                  state_ff   <= ST_CHECK;
               end else if (last_slot) begin
                  state_ff <= ST_MISS;
               end else begin
                  idx_ff <= idx_ff + AW'(1);
               end
            end
            ST_MISS: begin
               if (fill_ff == CW'(ENTRIES)) begin
                  // table full: accept without tracking
                  untracked_ff <= 1'b1;
                  state_ff     <= ST_FINISH;
               end else begin
                  rec_ff.address     <= ip_ff;
                  rec_ff.last_time   <= now_ff;
                  rec_ff.attempts    <= 8'd1;
                  rec_ff.block_until <= '0;
                  hit_idx_ff         <= fill_ff[AW-1:0];
                  fill_ff            <= fill_ff + CW'(1);
                  state_ff           <= ST_WRITE;
               end
            end
            ST_CHECK: begin
               state_ff <= alu_carry ? ST_GAP : ST_EXTEND;
            end
            ST_EXTEND: begin
               rec_ff.block_until <= alu_result;
               accept_ff          <= 1'b0;
               state_ff           <= ST_WRITE;
            end
            ST_GAP: begin
               // time going back counts as a zero gap
               gap_ff           <= alu_carry ? alu_result : '0;
               rec_ff.last_time <= now_ff;
               state_ff         <= ST_DECIDE;
            end
            ST_DECIDE: begin
               if (!in_window) begin
                  rec_ff.attempts <= 8'd1;
                  state_ff        <= ST_WRITE;
               end else if (!over_limit) begin
                  rec_ff.attempts <= next_attempts[7:0];
                  state_ff        <= ST_WRITE;
               end else begin
                  rec_ff.attempts <= 8'd0;
                  state_ff        <= in_fast ? ST_BLOCK : ST_WRITE;
               end
            end
            ST_BLOCK: begin
               rec_ff.block_until <= alu_result;
               accept_ff          <= 1'b0;
               state_ff           <= ST_WRITE;
            end
            ST_WRITE: begin
               wr_addr_ff <= hit_idx_ff;
               wr_data_ff <= rec_ff;
               state_ff   <= ST_FINISH;
            end
            ST_FINISH: begin
               // hold until the output register is free
               if (finish_go) begin
                  rsp_data_ff.accept    <= accept_ff;
                  rsp_data_ff.untracked <= untracked_ff;
                  state_ff              <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule
